// ===== design/divider_timer_with_reload_top_assert.svh =====
// ----------------------------------------------------------------------------
// Divider timer assertion macros
// Shared concurrent assertion forms, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIVIDER_TIMER_WITH_RELOAD_TOP_ASSERT_SVH
`define DIVIDER_TIMER_WITH_RELOAD_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("divider timer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DTR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("divider timer assertion failed");

`endif

// ===== design/dtr_pkg.sv =====
// ----------------------------------------------------------------------------
// Divider timer package
// Request and response types, register addresses and timer constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtr_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [15:0] ADDR_DIV = 16'hFF04;
   localparam logic [15:0] ADDR_CNT = 16'hFF05;
   localparam logic [15:0] ADDR_RLD = 16'hFF06;
   localparam logic [15:0] ADDR_CTL = 16'hFF07;

   localparam logic [15:0] DIV_RESET     = 16'hABCC;
   localparam logic [7:0]  CTL_READ_MASK = 8'hF8;
   localparam logic [7:0]  UNMAPPED_DATA = 8'hFF;
   localparam int          CTL_ENABLE    = 2;

   // Divider bit watched by the counter for each mode.
   localparam logic [3:0] MODE_BIT [4] = '{4'd10, 4'd4, 4'd6, 4'd8};

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] addr;
      logic [7:0]  write_data;
   } dtr_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_request;
   } dtr_rsp_type;

endpackage

`default_nettype wire

// ===== design/dtr_core.sv =====
// ----------------------------------------------------------------------------
// Divider timer core
// Holds the timer state and executes one request per enabled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "divider_timer_with_reload_top_assert.svh"

module dtr_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 exec,
   input  wire dtr_pkg::dtr_req_type req,
   output dtr_pkg::dtr_rsp_type      rsp
);
   import dtr_pkg::*;

   logic [15:0] divider_ff, divider_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  reload_ff, reload_in;
   logic [2:0]  control_ff, control_in;
   logic [15:0] saved_ff, saved_in;

   logic [15:0] div_inc;
   logic [15:0] toggled;
   logic [3:0]  watch_bit;
   logic        step;
   logic [7:0]  count_inc;

   assign div_inc   = divider_ff + 16'd1;
   assign toggled   = div_inc ^ divider_ff;
   assign watch_bit = MODE_BIT[control_ff[1:0]];
   assign count_inc = count_ff + 8'd1;

   always_comb begin
      divider_in = divider_ff;
      count_in   = count_ff;
      reload_in  = reload_ff;
      control_in = control_ff;
      saved_in   = saved_ff;
      step       = 1'b0;
      rsp        = '0;
      unique case (req.opcode)
         OP_TICK: begin
            divider_in = div_inc;
            if (control_ff[CTL_ENABLE]) begin
               // A pending divider write is consumed in place of the edge test,
               // and it looks one bit below the watched bit.
               if (saved_ff != 16'd0) begin
                  saved_in = '0;
                  step     = saved_ff[watch_bit - 4'd1];
               end else begin
                  step = toggled[watch_bit];
               end
            end
            if (step) begin
               if (count_inc == 8'd0) begin
                  count_in        = reload_ff;
                  rsp.irq_request = 1'b1;
               end else begin
                  count_in = count_inc;
               end
            end
         end
         OP_READ: begin
            unique case (req.addr)
               ADDR_DIV: rsp.read_data = divider_ff[15:8];
               ADDR_CNT: rsp.read_data = count_ff;
               ADDR_RLD: rsp.read_data = reload_ff;
               ADDR_CTL: rsp.read_data = CTL_READ_MASK | {5'd0, control_ff};
               default:  rsp.read_data = UNMAPPED_DATA;
            endcase
         end
         OP_WRITE: begin
            unique case (req.addr)
               ADDR_DIV: begin
                  saved_in   = divider_ff;
                  divider_in = '0;
               end
               ADDR_CNT: count_in   = req.write_data;
               ADDR_RLD: reload_in  = req.write_data;
               ADDR_CTL: control_in = req.write_data[2:0];
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= DIV_RESET;
         count_ff   <= '0;
         reload_ff  <= '0;
         control_ff <= '0;
         saved_ff   <= '0;
      end else if (exec) begin
         divider_ff <= divider_in;
         count_ff   <= count_in;
         reload_ff  <= reload_in;
         control_ff <= control_in;
         saved_ff   <= saved_in;
      end
   end

   `DTR_ASSERT_NEXT(a_div_write_clears, exec && req.opcode == OP_WRITE && req.addr == ADDR_DIV, divider_ff == 16'd0)
   `DTR_ASSERT_NEXT(a_saved_consumed, exec && req.opcode == OP_TICK && control_ff[CTL_ENABLE], saved_ff == 16'd0)
   `DTR_ASSERT_SAME(a_irq_only_tick, rsp.irq_request, req.opcode == OP_TICK && count_in == reload_ff)

endmodule

`default_nettype wire

// ===== design/divider_timer_with_reload_top.sv =====
// Path: request in the input register, then its response in the response register.
// Throughput: one request per cycle; a request is stalled only while the input register
// is full and the response register holds a response that is itself stalled.
// Reset: synchronous, active high; divider returns to 0xABCC, other timer state to zero,
// and both pipeline registers are emptied.
// ----------------------------------------------------------------------------
// Divider timer with reload, top level
// Input register, timer core and response register with valid/stall handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "divider_timer_with_reload_top_assert.svh"

module divider_timer_with_reload_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [15:0] req_addr,
   input  wire logic [7:0]  req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_irq_request
);
   import dtr_pkg::*;

   logic        in_valid_ff;
   dtr_req_type req_ff;
   logic        out_valid_ff;
   dtr_rsp_type rsp_ff;
   dtr_rsp_type core_rsp;
   logic        out_ready;
   logic        advance;

   // The response register can load when it is empty or being drained.
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   dtr_core u_core (
      .clock (clock),
      .reset (reset),
      .exec  (advance),
      .req   (req_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_ready) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= '{opcode: req_opcode, addr: req_addr, write_data: req_write_data};
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_irq_request = rsp_ff.irq_request;

   `DTR_ASSERT_SAME(a_stall_when_full, in_valid_ff && out_valid_ff && rsp_stall, req_stall)
   `DTR_ASSERT_NEXT(a_request_moves, in_valid_ff && !(out_valid_ff && rsp_stall), rsp_valid)
   `DTR_ASSERT_SAME(a_irq_no_data, rsp_valid && rsp_irq_request, rsp_read_data == 8'd0)

endmodule

`default_nettype wire
